FILE: design/swta_pkg.sv
// ----------------------------------------------------------------------------
// swta_pkg
// Shared types and constants of the stereo winner-take-all cost chain.
// ----------------------------------------------------------------------------
package swta_pkg;

  // one packed pixel: Y in the low byte, then Cb, then Cr
  localparam int PIX_W  = 24;
  localparam int COST_W = 16;
  localparam int DISP_W = 9;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [COST_W-1:0] cost_t;
  typedef logic [DISP_W-1:0] disp_t;

  // cost weights and the out-of-row cost
  localparam cost_t LUMA_WEIGHT   = 16'd170;
  localparam cost_t CHROMA_WEIGHT = 16'd43;
  localparam cost_t COST_MAX      = 16'hFFFF;

  // one pixel evaluation travelling down the cell chain
  typedef struct packed {
    logic  valid;
    pix_t  left;
    cost_t best;
    disp_t disp;
    logic  row_last;
    logic  run_last;
  } tok_t;

endpackage

FILE: design/swta_cell.sv
// ----------------------------------------------------------------------------
// swta_cell
// One window column and one disparity compare step of the cost chain.
// ----------------------------------------------------------------------------
module swta_cell #(
  parameter int CELL_IDX = 0,
  parameter int IDX_W    = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // window shift, one column per accepted input
  input  logic              shift_en_i,
  input  swta_pkg::pix_t    pix_l_i,
  input  swta_pkg::pix_t    pix_r_i,
  output swta_pkg::pix_t    pix_l_o,
  output swta_pkg::pix_t    pix_r_o,
  // evaluation token from the upper neighbor
  input  logic              en_i,
  input  swta_pkg::tok_t    tok_i,
  input  logic [IDX_W-1:0]  tok_j_i,
  input  logic [IDX_W-1:0]  tok_klo_i,
  output swta_pkg::tok_t    tok_o,
  output logic [IDX_W-1:0]  tok_j_o,
  output logic [IDX_W-1:0]  tok_klo_o
);
  import swta_pkg::*;

  localparam logic [IDX_W-1:0] K = IDX_W'(CELL_IDX);

  pix_t             left_q, right_q;
  tok_t             tok_q, tok_d;
  logic [IDX_W-1:0] j_q, klo_q;
  pix_t             lsel;
  cost_t            cost;
  logic             hit;
  logic [IDX_W-1:0] dd;

  function automatic cost_t match_cost(pix_t l, pix_t r);
    logic [7:0] dy, dcb, dcr;
    logic [8:0] dc;
    dy  = (l[7:0]   > r[7:0])   ? l[7:0]   - r[7:0]   : r[7:0]   - l[7:0];
    dcb = (l[15:8]  > r[15:8])  ? l[15:8]  - r[15:8]  : r[15:8]  - l[15:8];
    dcr = (l[23:16] > r[23:16]) ? l[23:16] - r[23:16] : r[23:16] - l[23:16];
    dc  = {1'b0, dcb} + {1'b0, dcr};
    return COST_W'(dy) * LUMA_WEIGHT + COST_W'(dc) * CHROMA_WEIGHT;
  endfunction

  // window column, shifted toward older columns
  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      left_q  <= pix_l_i;
      right_q <= pix_r_i;
    end
  end

  // this cell covers disparity j-K for the token's pixel
  always_comb begin
    hit  = tok_i.valid && (K <= tok_j_i) && (K >= tok_klo_i);
    lsel = (tok_j_i == K) ? left_q : tok_i.left;
    cost = match_cost(lsel, right_q);
    dd   = tok_j_i - K;
    tok_d      = tok_i;
    tok_d.left = lsel;
    if (hit && (cost < tok_i.best)) begin
      tok_d.best = cost;
      tok_d.disp = DISP_W'({dd, 3'b000});
    end
  end

  // token register, stalls with the whole chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      j_q   <= '0;
      klo_q <= '0;
    end else if (en_i) begin
      tok_q <= tok_d;
      j_q   <= tok_j_i;
      klo_q <= tok_klo_i;
    end
  end

  assign pix_l_o   = left_q;
  assign pix_r_o   = right_q;
  assign tok_o     = tok_q;
  assign tok_j_o   = j_q;
  assign tok_klo_o = klo_q;

endmodule

FILE: design/stereo_cost_winner_take_all.sv
// ----------------------------------------------------------------------------
// stereo_cost_winner_take_all
// Absolute-difference stereo matcher with winner-take-all disparity search.
// ----------------------------------------------------------------------------
// Each input transaction carries one column of left and right YCbCr pixels
// and shifts them into a chain of MAX_DISPARITY cells that holds the most
// recent columns of the row. The pixel whose window is complete is then sent
// down the chain as a token that visits one cell per cycle unless the chain
// stalls, each cell testing one disparity. Tokens are launched one per cycle
// unless stalled; no new input is taken until an input's last token reaches
// the output; an input that yields no result leaves the block ready. At end
// of row up to max(disparity_range, 1), at most MAX_DISPARITY, results are
// flushed in pixel order. Output backpressure stalls the whole chain. There is
// no clearing pass after reset: window columns are only read once written.
module stereo_cost_winner_take_all #(
  parameter int MAX_DISPARITY = 64,
  parameter int MAX_ROW_WIDTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: disparity_range
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  // pixel input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // left_luma, left_blue_chroma, left_red_chroma,
  // right_luma, right_blue_chroma, right_red_chroma
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // end_of_row
  // disparity output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // disparity, best_cost, zero fill
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,   // row_last
  output logic        m_axis_tuser    // run_last
);
  import swta_pkg::*;

  localparam int IDX_W = $clog2(MAX_DISPARITY);
  localparam int COL_W = $clog2(MAX_ROW_WIDTH);
  localparam int XW    = (COL_W > IDX_W) ? COL_W : IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LAUNCH = 3'b010,
    ST_DRAIN  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [6:0]       range_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic             eor_q, eor_d;
  logic [IDX_W-1:0] rm1;
  logic [8:0]       rng_x;
  logic [XW-1:0]    col_x, rm1_x;
  logic             in_acc, eor_in, emit, last_tok, en;
  logic [IDX_W-1:0] jstart;
  tok_t             launch_tok_d, launch_tok_q;
  logic [IDX_W-1:0] launch_j_q, launch_klo_q, launch_klo_d;

  pix_t             pix_l [MAX_DISPARITY];
  pix_t             pix_r [MAX_DISPARITY];
  tok_t             tok   [MAX_DISPARITY+1];
  logic [IDX_W-1:0] tok_j   [MAX_DISPARITY+1];
  logic [IDX_W-1:0] tok_klo [MAX_DISPARITY+1];

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= 7'd64;
    end else if (cfg_valid_i) begin
      range_q <= cfg_data_i;
    end
  end

  // effective range minus one, clamped to the chain length
  always_comb begin
    rng_x = {2'b00, range_q};
    if (rng_x == 9'd0) begin
      rm1 = '0;
    end else if (rng_x > 9'(MAX_DISPARITY)) begin
      rm1 = IDX_W'(MAX_DISPARITY - 1);
    end else begin
      rm1 = IDX_W'(rng_x - 9'd1);
    end
  end

  // input decode
  always_comb begin
    in_acc  = s_axis_tvalid && s_axis_tready;
    eor_in  = s_axis_tlast || (col_q == COL_W'(MAX_ROW_WIDTH - 1));
    col_x   = XW'(col_q);
    rm1_x   = XW'(rm1);
    emit    = eor_in || (col_x >= rm1_x);
    jstart  = (col_x < rm1_x) ? IDX_W'(col_x) : rm1;
    last_tok = !eor_q || (j_q == '0);
    en      = !tok[0].valid || m_axis_tready;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    j_d     = j_q;
    eor_d   = eor_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          col_d = eor_in ? '0 : col_q + COL_W'(1);
          if (emit) begin
            state_d = ST_LAUNCH;
            j_d     = jstart;
            eor_d   = eor_in;
          end
        end
      end
      ST_LAUNCH: begin
        if (en) begin
          if (last_tok) begin
            state_d = ST_DRAIN;
          end else begin
            j_d = j_q - IDX_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (en && tok[1].valid && tok[1].run_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      j_q     <= '0;
      eor_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      j_q     <= j_d;
      eor_q   <= eor_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // launch stage: one pixel token per cycle while the chain is not stalled
  always_comb begin
    launch_tok_d          = '0;
    launch_tok_d.valid    = (state_q == ST_LAUNCH);
    launch_tok_d.best     = COST_MAX;
    launch_tok_d.row_last = eor_q && (j_q == '0);
    launch_tok_d.run_last = last_tok;
    launch_klo_d          = (j_q >= rm1) ? j_q - rm1 : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_tok_q <= '0;
      launch_j_q   <= '0;
      launch_klo_q <= '0;
    end else if (en) begin
      launch_tok_q <= launch_tok_d;
      launch_j_q   <= j_q;
      launch_klo_q <= launch_klo_d;
    end
  end

  assign tok[MAX_DISPARITY]     = launch_tok_q;
  assign tok_j[MAX_DISPARITY]   = launch_j_q;
  assign tok_klo[MAX_DISPARITY] = launch_klo_q;

  // cell chain: pixels move up, tokens move down
  for (genvar k = 0; k < MAX_DISPARITY; k++) begin : g_cell
    pix_t l_in, r_in;
    if (k == 0) begin : g_head
      assign l_in = s_axis_tdata[23:0];
      assign r_in = s_axis_tdata[47:24];
    end else begin : g_link
      assign l_in = pix_l[k-1];
      assign r_in = pix_r[k-1];
    end
    swta_cell #(
      .CELL_IDX (k),
      .IDX_W    (IDX_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (in_acc),
      .pix_l_i    (l_in),
      .pix_r_i    (r_in),
      .pix_l_o    (pix_l[k]),
      .pix_r_o    (pix_r[k]),
      .en_i       (en),
      .tok_i      (tok[k+1]),
      .tok_j_i    (tok_j[k+1]),
      .tok_klo_i  (tok_klo[k+1]),
      .tok_o      (tok[k]),
      .tok_j_o    (tok_j[k]),
      .tok_klo_o  (tok_klo[k])
    );
  end

  // output from the last cell of the chain
  assign m_axis_tvalid = tok[0].valid;
  assign m_axis_tdata  = {7'd0, tok[0].best, tok[0].disp};
  assign m_axis_tlast  = tok[0].row_last;
  assign m_axis_tuser  = tok[0].run_last;

  // no input transaction while a token sits in the launch stage
  a_launch_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_tok_q.valid |-> !s_axis_tready)
    else $error("input taken while a launch token is pending");

  // the cell just above the output holds no token whenever new input can shift it
  a_idle_chain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !tok[1].valid)
    else $error("token in flight while idle");

  // disparity zero is always in the row, so a real cost always wins
  a_cost_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (tok[0].best != COST_MAX))
    else $error("result without an in-row cost");

  // a stalled chain keeps its output result
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(tok[0]))
    else $error("output result changed while stalled");

endmodule

FILE: tb/stereo_cost_winner_take_all_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_cost_winner_take_all_tb
// Self-checking bench for the stereo winner-take-all disparity search.
// ----------------------------------------------------------------------------
// A driver streams pixel columns from a queue that the main sequence fills,
// and a monitor predicts the winning disparity and cost of every completed
// window. It compares each output transaction against the oldest prediction.
// The run covers directed corner rows and random rows in phases with
// different disparity ranges and idle/stall patterns.
module stereo_cost_winner_take_all_tb;
  import swta_pkg::*;

  localparam int MAX_DISP     = 64;
  localparam int ROW_MAX      = 4096;
  localparam int DISP_STEP    = 8;
  localparam int DRAIN_CYCLES = 3 * MAX_DISP;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 100;
  localparam pix_t NOISE_MASK = 24'h030303;

  typedef enum logic [1:0] {
    ROW_NOISE,
    ROW_SHIFTED,
    ROW_FLAT
  } row_kind_e;

  // one pixel column waiting to be sent
  typedef struct {
    pix_t left;
    pix_t right;
    logic eor;
  } column_t;

  // one predicted or observed winner
  typedef struct packed {
    disp_t disparity;
    cost_t best_cost;
    logic  row_last;
    logic  run_last;
  } winner_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;    // left Y, Cb, Cr, right Y, Cb, Cr
  logic        s_axis_tlast;    // end of row
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;    // disparity, best cost, zero fill
  logic        m_axis_tlast;    // row last
  logic        m_axis_tuser;    // run last

  // stimulus and scoreboard
  column_t     column_q [$];
  winner_t     winner_q [$];
  column_t     next_col;
  winner_t     got_win;
  winner_t     want_win;
  logic        col_taken;
  int unsigned send_idle_pct;
  int unsigned ready_stall_pct;
  int unsigned quiet_cycles;
  int unsigned mismatches;

  // predictor state
  pix_t        left_win [MAX_DISP];
  pix_t        right_win [MAX_DISP];
  logic [6:0]  pred_range = 7'd64;
  int unsigned pred_col = 0;

  stereo_cost_winner_take_all #(
    .MAX_DISPARITY(MAX_DISP),
    .MAX_ROW_WIDTH(ROW_MAX)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned byte_dist(logic [7:0] a, logic [7:0] b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  function automatic int unsigned pair_cost(pix_t a, pix_t b);
    return int'(LUMA_WEIGHT) * byte_dist(a[7:0], b[7:0]) +
           int'(CHROMA_WEIGHT) * (byte_dist(a[15:8], b[15:8]) +
                                  byte_dist(a[23:16], b[23:16]));
  endfunction

  // best disparity for left pixel p with columns up to c known
  function automatic winner_t search_window(int unsigned p, int unsigned c,
                                            int unsigned rng, logic last);
    winner_t     w;
    int unsigned best;
    int unsigned win;
    int unsigned cost;
    int unsigned d;
    best = int'(COST_MAX);
    win  = 0;
    for (d = 0; d < rng; d++) begin
      if (p + d > c) begin
        cost = int'(COST_MAX);
      end else begin
        cost = pair_cost(left_win[p % MAX_DISP], right_win[(p + d) % MAX_DISP]);
      end
      if (cost < best) begin
        best = cost;
        win  = d;
      end
    end
    w.disparity = disp_t'(win * DISP_STEP);
    w.best_cost = cost_t'(best);
    w.row_last  = last;
    w.run_last  = 1'b0;
    return w;
  endfunction

  // update the row state for one accepted column and queue its winners
  task automatic predict_winners(pix_t lp, pix_t rp, logic eor_in);
    int unsigned col;
    int unsigned rng;
    int unsigned p;
    logic        eor;
    winner_t     w;
    rng = pred_range;
    if (rng < 1) rng = 1;
    if (rng > MAX_DISP) rng = MAX_DISP;
    col = pred_col;
    if (col > ROW_MAX - 1) col = ROW_MAX - 1;
    eor = eor_in || (col >= ROW_MAX - 1);
    left_win[col % MAX_DISP]  = lp;
    right_win[col % MAX_DISP] = rp;
    if (eor) begin
      // flush every pixel still open in the row
      p = (col >= rng - 1) ? col - (rng - 1) : 0;
      while (p <= col) begin
        w = search_window(p, col, rng, p == col);
        w.run_last = (p == col);
        winner_q.push_back(w);
        p++;
      end
      pred_col = 0;
    end else begin
      if (col >= rng - 1) begin
        w = search_window(col - (rng - 1), col, rng, 1'b0);
        w.run_last = 1'b1;
        winner_q.push_back(w);
      end
      pred_col = (col + 1) & 32'h1FFF;
    end
  endtask

  task automatic queue_column(pix_t lp, pix_t rp, logic eor);
    column_t c;
    c.left  = lp;
    c.right = rp;
    c.eor   = eor;
    column_q.push_back(c);
  endtask

  // a row of the given kind; a shifted row's left view is the right view moved by the shift
  task automatic queue_row(int unsigned len, int unsigned shift, row_kind_e kind,
                           bit close_row);
    pix_t        scene [$];
    pix_t        flat_pix;
    pix_t        lp;
    int unsigned i;
    flat_pix = pix_t'($urandom());
    for (i = 0; i < len + shift; i++) begin
      scene.push_back((kind == ROW_FLAT) ? flat_pix : pix_t'($urandom()));
    end
    for (i = 0; i < len; i++) begin
      case (kind)
        ROW_NOISE: begin
          lp = pix_t'($urandom());
        end
        ROW_SHIFTED: begin
          lp = scene[i + shift];
          if ($urandom_range(1) != 0) lp = lp ^ (pix_t'($urandom()) & NOISE_MASK);
        end
        default: begin
          lp = flat_pix;
        end
      endcase
      queue_column(lp, scene[i], close_row && (i == len - 1));
    end
  endtask

  // sender done and every winner seen, then let the cell chain drain
  task automatic wait_idle();
    while (column_q.size() != 0 || s_axis_tvalid || winner_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_range(logic [6:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // driver: pixel source and result sink
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= ready_stall_pct);
      if (!s_axis_tvalid || col_taken) begin
        if (column_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_col = column_q.pop_front();
          s_axis_tdata  <= {next_col.right, next_col.left};
          s_axis_tlast  <= next_col.eor;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check results, track config, predict on accepted columns
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      col_taken <= 1'b0;
    end else begin
      col_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got_win.disparity = m_axis_tdata[DISP_W-1:0];
        got_win.best_cost = m_axis_tdata[DISP_W+COST_W-1:DISP_W];
        got_win.row_last  = m_axis_tlast;
        got_win.run_last  = m_axis_tuser;
        if (winner_q.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: disparity %0d cost %0d row_last %0b run_last %0b",
                   $time, got_win.disparity, got_win.best_cost, got_win.row_last,
                   got_win.run_last);
        end else begin
          want_win = winner_q.pop_front();
          if (got_win !== want_win) begin
            mismatches++;
            $display("%0t mismatch: expected disp %0d cost %0d row_last %0b run_last %0b, %s",
                     $time, want_win.disparity, want_win.best_cost, want_win.row_last,
                     want_win.run_last, $sformatf("got disp %0d cost %0d row_last %0b run_last %0b",
                     got_win.disparity, got_win.best_cost, got_win.row_last, got_win.run_last));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) pred_range = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_winners(s_axis_tdata[23:0], s_axis_tdata[47:24], s_axis_tlast);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < QUIET_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("FAIL");
      $finish;
    end
  end

  // main sequence
  initial begin
    int unsigned phase;
    int unsigned queued;
    int unsigned len;
    row_kind_e   kind;
    bit          paused;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tlast    = 1'b0;
    m_axis_tready   = 1'b0;
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    mismatches      = 0;
    paused          = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single-pixel row at reset range, largest possible cost
    queue_column(24'hFFFFFF, 24'h000000, 1'b1);
    wait_idle();
    // range zero acts as one: every column resolves at once
    write_range(7'd0);
    queue_column(24'h000000, 24'h000000, 1'b0);
    queue_column(24'h00FF00, 24'hFF00FF, 1'b0);
    queue_column(24'hFF0000, 24'hFF0000, 1'b1);
    wait_idle();
    // flat row, all costs tie
    write_range(7'd2);
    queue_row(4, 0, ROW_FLAT, 1'b1);
    wait_idle();
    // range above the maximum is clamped, row shorter than the range
    write_range(7'd127);
    queue_row(5, 3, ROW_SHIFTED, 1'b1);
    wait_idle();
    // range change in the middle of a row
    write_range(7'd5);
    queue_row(7, 2, ROW_SHIFTED, 1'b0);
    wait_idle();
    write_range(7'd3);
    queue_row(4, 1, ROW_SHIFTED, 1'b1);

    // random rows, one range and idle pattern per phase
    for (phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          send_idle_pct = 0;  ready_stall_pct = 0;
          write_range(7'd64);
        end
        1: begin
          send_idle_pct = 74; ready_stall_pct = 0;
          write_range(7'd1);
        end
        2: begin
          send_idle_pct = 0;  ready_stall_pct = 74;
          write_range(7'($urandom_range(2, 63)));
        end
        default: begin
          send_idle_pct = 6;  ready_stall_pct = 6;
          write_range(7'($urandom_range(0, 127)));
        end
      endcase
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        // sender holds off until every pending winner is out
        if (phase == 2 && !paused && queued >= PHASE_ITEMS / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        len = ($urandom_range(7) == 0) ? $urandom_range(65, 140) : $urandom_range(1, 40);
        case ($urandom_range(9))
          0:       kind = ROW_FLAT;
          1, 2:    kind = ROW_NOISE;
          default: kind = ROW_SHIFTED;
        endcase
        queue_row(len, $urandom_range(0, 70), kind, $urandom_range(5) != 0);
        queued += len;
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
